FILE: design/rr_interval_session_recorder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heart-beat interval session recorder
// Concurrent checks clocked on clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RR_INTERVAL_SESSION_RECORDER_TOP_ASSERT_SVH
`define RR_INTERVAL_SESSION_RECORDER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RRSR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication whose consequent is checked in the same cycle.
`define RRSR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/rrsr_pkg.sv
// ----------------------------------------------------------------------------
// rrsr_pkg: shared types and constants
// Word layouts, session phase coding and the allowed session lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package rrsr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned MS_PER_SEC      = 1000;

  // Allowed session lengths in seconds.
  localparam int unsigned LEN_A_SEC = 30;
  localparam int unsigned LEN_B_SEC = 120;
  localparam int unsigned LEN_C_SEC = 180;
  localparam int unsigned LEN_D_SEC = 300;

  localparam logic [18:0] LEN_A_MS = 19'(LEN_A_SEC * MS_PER_SEC);
  localparam logic [18:0] LEN_B_MS = 19'(LEN_B_SEC * MS_PER_SEC);
  localparam logic [18:0] LEN_C_MS = 19'(LEN_C_SEC * MS_PER_SEC);
  localparam logic [18:0] LEN_D_MS = 19'(LEN_D_SEC * MS_PER_SEC);

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_FEED  = 3'd2,
    MODE_POLL  = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_INTERVAL_MIN = 2'd0,
    CFG_INTERVAL_MAX = 2'd1,
    CFG_GRACE        = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_REC  = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_e;

  localparam logic [1:0] STATE_CODE_IDLE = 2'd0;
  localparam logic [1:0] STATE_CODE_REC  = 2'd1;
  localparam logic [1:0] STATE_CODE_DONE = 2'd2;
  localparam logic [1:0] STATE_CODE_ERR  = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [15:0] length_sec;
    logic [15:0] rr_interval;
    logic        link_up;
    logic [9:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  session_state;
    logic [10:0] entry_count;
    logic [18:0] run_ms;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] interval_min_ms;
    logic [15:0] interval_max_ms;
    logic [31:0] grace_ms;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [18:0] session_ms;
    logic [31:0] start_ms;
    logic [18:0] run_ms;
    logic [31:0] loss_ms;
    logic        loss_valid;
  } sess_t;

  // Session length in ms for an allowed length, zero for any other.
  function automatic logic [18:0] session_ms_of(input logic [15:0] dur);
    logic [18:0] ms;
    case (dur)
      16'(LEN_A_SEC): ms = LEN_A_MS;
      16'(LEN_B_SEC): ms = LEN_B_MS;
      16'(LEN_C_SEC): ms = LEN_C_MS;
      16'(LEN_D_SEC): ms = LEN_D_MS;
      default:        ms = '0;
    endcase
    return ms;
  endfunction

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE: code = STATE_CODE_IDLE;
      PH_REC:  code = STATE_CODE_REC;
      PH_DONE: code = STATE_CODE_DONE;
      PH_ERR:  code = STATE_CODE_ERR;
      default: code = STATE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: design/rrsr_if.sv
// ----------------------------------------------------------------------------
// rrsr_if: handshake channels of the session recorder
// Command words in, result words out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrsr_item_if;
  logic               valid;
  logic               ready;
  rrsr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrsr_res_if;
  logic                valid;
  logic                ready;
  rrsr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: design/rr_interval_session_recorder_top.sv
// An accepted word passes the update step and its result is then held in the result register out_q.
// A new word is taken only once the update of the last one is done; the single-port store reads
// at acceptance and writes back in the update step.
// A waiting result word stalls the update cycle and with it the acceptance of the next word.
// Reset (rst_ni low, asynchronous) returns to idle with the default limits;
// the store contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// rr_interval_session_recorder_top: heart-beat interval session recorder
// Records beat-to-beat intervals for a timed session and answers reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rr_interval_session_recorder_top #(
  parameter int unsigned STORE_DEPTH = rrsr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rrsr_cfg_if.sink    cfg_i,
  rrsr_item_if.sink   in_i,
  rrsr_res_if.source  out_o
);

  import rrsr_pkg::*;

  `include "rr_interval_session_recorder_top_assert.svh"

  // Store address width and a count width that can hold the full depth.
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  // Two-step sequencer: the store read is issued while the word is accepted,
  // and the update happens once the read data is there and the result
  // register is free.
  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_EXEC = 2'b10
  } ctl_e;

  ctl_e      ctl_q, ctl_d;
  cfg_t      cfg_q;
  sess_t     sess_q, sess_d, sess_nxt;
  logic [CW-1:0] count_q, count_d, count_nxt;
  in_item_t  item_q;
  out_item_t out_q, res;
  logic      out_valid_q, out_valid_d;

  logic          in_fire;
  logic          exec_done;
  logic          ex_we;
  logic          store_we;
  logic [AW-1:0] store_addr;
  logic [AW-1:0] rd_addr;
  logic [31:0]   idx_ext;
  logic [15:0]   store_rdata;

  assign in_fire   = in_i.valid && in_i.ready;
  assign exec_done = (ctl_q == C_EXEC) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (ctl_q == C_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign cfg_i.ready = 1'b1;

  // The read index is narrowed to the store address; an index beyond the
  // fill count is never answered with store data, so aliasing is harmless.
  assign idx_ext    = 32'(in_i.data.read_index);
  assign rd_addr    = idx_ext[AW-1:0];
  assign store_addr = (ctl_q == C_EXEC) ? count_q[AW-1:0] : rd_addr;
  assign store_we   = exec_done && ex_we;

  rrsr_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (16)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .re_i    (in_fire),
    .addr_i  (store_addr),
    .wdata_i (item_q.rr_interval),
    .rdata_o (store_rdata)
  );

  rrsr_exec #(
    .STORE_DEPTH (STORE_DEPTH),
    .CW          (CW)
  ) u_exec (
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .sess_i     (sess_q),
    .count_i    (count_q),
    .rdata_i    (store_rdata),
    .sess_o     (sess_nxt),
    .count_o    (count_nxt),
    .store_we_o (ex_we),
    .res_o      (res)
  );

  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      C_IDLE: begin
        if (in_fire) begin
          ctl_d = C_EXEC;
        end
      end
      C_EXEC: begin
        if (exec_done) begin
          ctl_d = C_IDLE;
        end
      end
      default: ctl_d = C_IDLE;
    endcase
  end

  assign sess_d  = exec_done ? sess_nxt : sess_q;
  assign count_d = exec_done ? count_nxt : count_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= C_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      sess_q      <= '{phase: PH_IDLE, default: '0};
    end else begin
      ctl_q       <= ctl_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      sess_q      <= sess_d;
    end
  end

  // Limit registers; writes to an index beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_min_ms <= 16'd300;
      cfg_q.interval_max_ms <= 16'd2000;
      cfg_q.grace_ms        <= 32'd10000;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_INTERVAL_MIN: cfg_q.interval_min_ms <= cfg_i.wdata[15:0];
        CFG_INTERVAL_MAX: cfg_q.interval_max_ms <= cfg_i.wdata[15:0];
        CFG_GRACE:        cfg_q.grace_ms        <= cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
    end
    if (exec_done) begin
      out_q <= res;
    end
  end

  // The fill count never passes the store depth.
  `RRSR_ASSERT(a_count_bound, 32'(count_q) <= 32'(STORE_DEPTH), "fill count beyond store depth")
  // A store write only lands on a free entry.
  `RRSR_ASSERT_IMP(a_write_room, store_we, 32'(count_q) < 32'(STORE_DEPTH), "write to full store")
  // A result word appears only after an update cycle.
  `RRSR_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(ctl_q == C_EXEC), "result without update")
  // An idle session holds no intervals.
  `RRSR_ASSERT_IMP(a_idle_empty, sess_q.phase == PH_IDLE, count_q == '0, "idle with stored entries")

endmodule

`default_nettype wire

FILE: design/rrsr_store.sv
// ----------------------------------------------------------------------------
// rrsr_store: interval store
// Single-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsr_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/rrsr_exec.sv
// ----------------------------------------------------------------------------
// rrsr_exec: command execution
// Computes the next session state, the store write and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rrsr_exec #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned CW          = 11
) (
  input  rrsr_pkg::in_item_t  item_i,
  input  rrsr_pkg::cfg_t      cfg_i,
  input  rrsr_pkg::sess_t     sess_i,
  input  wire logic [CW-1:0]  count_i,
  input  wire logic [15:0]    rdata_i,
  output rrsr_pkg::sess_t     sess_o,
  output logic      [CW-1:0]  count_o,
  output logic                store_we_o,
  output rrsr_pkg::out_item_t res_o
);

  import rrsr_pkg::*;

  logic [31:0] el;
  logic [31:0] dur_ms;
  logic [31:0] loss_ref;
  logic [31:0] gone_ms;
  logic [18:0] start_len;
  logic        start_ok;
  logic        in_range;
  logic        has_room;
  logic        failed;
  logic        acc;
  logic [15:0] rval;
  logic [18:0] shown;
  logic [31:0] cnt_ext;

  assign el        = item_i.now_ms - sess_i.start_ms;
  assign dur_ms    = 32'(sess_i.session_ms);
  assign loss_ref  = sess_i.loss_valid ? sess_i.loss_ms : item_i.now_ms;
  assign gone_ms   = item_i.now_ms - loss_ref;
  assign start_len = session_ms_of(item_i.length_sec);
  assign start_ok  = (start_len != '0);
  assign in_range  = (item_i.rr_interval >= cfg_i.interval_min_ms) &&
                     (item_i.rr_interval <= cfg_i.interval_max_ms);
  assign has_room  = (32'(count_i) < 32'(STORE_DEPTH));
  assign cnt_ext   = 32'(count_i);

  always_comb begin
    sess_o     = sess_i;
    count_o    = count_i;
    store_we_o = 1'b0;
    acc        = 1'b0;
    rval       = '0;
    failed     = 1'b0;
    case (item_i.mode)
      MODE_START: begin
        if (start_ok) begin
          sess_o.phase      = PH_REC;
          sess_o.session_ms = start_len;
          sess_o.start_ms   = item_i.now_ms;
          sess_o.run_ms     = '0;
          sess_o.loss_ms    = '0;
          sess_o.loss_valid = 1'b0;
          count_o           = '0;
          acc               = 1'b1;
        end
      end
      MODE_STOP: begin
        sess_o.phase      = PH_IDLE;
        sess_o.session_ms = '0;
        sess_o.run_ms     = '0;
        sess_o.loss_ms    = '0;
        sess_o.loss_valid = 1'b0;
        count_o           = '0;
      end
      MODE_FEED: begin
        if (in_range && (sess_i.phase == PH_REC) && has_room) begin
          store_we_o = 1'b1;
          count_o    = count_i + CW'(1);
          acc        = 1'b1;
        end
      end
      MODE_POLL: begin
        if (sess_i.phase == PH_REC) begin
          if (item_i.link_up) begin
            sess_o.loss_valid = 1'b0;
            sess_o.loss_ms    = '0;
          end else begin
            sess_o.loss_valid = 1'b1;
            sess_o.loss_ms    = loss_ref;
            if ((gone_ms >= cfg_i.grace_ms) && (el < dur_ms)) begin
              sess_o.phase = PH_ERR;
              failed       = 1'b1;
            end
          end
          if (!failed && (el >= dur_ms)) begin
            sess_o.phase  = PH_DONE;
            sess_o.run_ms = sess_i.session_ms;
          end else begin
            sess_o.run_ms = el[18:0];
          end
        end
      end
      MODE_READ: begin
        if (32'(item_i.read_index) < cnt_ext) begin
          acc  = 1'b1;
          rval = rdata_i;
        end
      end
      default: begin
      end
    endcase
  end

  // While recording the live time is shown, capped at the session length; a fresh start shows zero.
  always_comb begin
    shown = sess_o.run_ms;
    if (sess_o.phase == PH_REC) begin
      if ((item_i.mode == MODE_START) && start_ok) begin
        shown = '0;
      end else if (el > dur_ms) begin
        shown = sess_i.session_ms;
      end else begin
        shown = el[18:0];
      end
    end
  end

  logic [31:0] cnt_out_ext;
  assign cnt_out_ext = 32'(count_o);

  assign res_o.accepted      = acc;
  assign res_o.session_state = phase_code(sess_o.phase);
  assign res_o.entry_count   = cnt_out_ext[10:0];
  assign res_o.run_ms        = shown;
  assign res_o.read_value    = rval;

endmodule

`default_nettype wire
